### rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the lock block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RLFH_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("lock block assertion failed");
`define RLFH_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("lock block forbidden condition seen");
`else
`define RLFH_ASSERT(label, clk, rstn, prop)
`define RLFH_NEVER(label, clk, rstn, cond)
`endif
`endif

### rtl/core/rlfh_pkg.sv
// Package with the codes and default sizes of the recursive lock block.
package rlfh_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_THREAD_BITS = 8;
  localparam int DEF_COUNT_BITS  = 16;

  typedef enum logic [0:0] {
    OP_LOCK   = 1'b0,
    OP_UNLOCK = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_NESTED  = 3'd1,
    ST_QUEUED  = 3'd2,
    ST_STILL   = 3'd3,
    ST_FREED   = 3'd4,
    ST_HANDOFF = 3'd5,
    ST_ERROR   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NOT_OWNER = 2'd1,
    ERR_FULL      = 2'd2,
    ERR_OVERFLOW  = 2'd3
  } err_t;

endpackage

### rtl/core/recursive_lock_fifo_handoff.sv
// Recursive lock with a first-in first-out wait queue held in a synchronous memory.
// An accepted request's result is registered. Throughput: one request per cycle while
// out_ready takes each result; the head entry of the wait memory is read ahead every
// cycle, with forwarding of a write to the same entry, so a handoff never stalls.
// Reset (synchronous, active low) frees the lock and empties the queue; the memory
// itself is not cleared, as an entry is only read after it has been written.
`include "assert_macros.svh"

module recursive_lock_fifo_handoff
  import rlfh_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int THREAD_BITS = DEF_THREAD_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  localparam int PTR_W      = $clog2(QUEUE_DEPTH),
  localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_opcode,
  input  logic [THREAD_BITS-1:0] in_thread_id,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_status,
  output logic [1:0]             out_error_kind,
  output logic [THREAD_BITS-1:0] out_woken_thread,
  output logic                   out_owner_held,
  output logic [THREAD_BITS-1:0] out_owner_thread,
  output logic [COUNT_BITS-1:0]  out_nest_depth,
  output logic [FILL_W-1:0]      out_waiters
);

  logic [THREAD_BITS-1:0] mem [QUEUE_DEPTH];

  logic                   held_r, held_nxt;
  logic [THREAD_BITS-1:0] owner_r, owner_nxt;
  logic [COUNT_BITS-1:0]  nest_r, nest_nxt;
  logic [PTR_W-1:0]       head_ptr_r, head_ptr_nxt;
  logic [PTR_W-1:0]       tail_ptr_r, tail_ptr_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [THREAD_BITS-1:0] head_data_r;

  logic                   out_valid_r;
  status_t                status_r, status_nxt;
  err_t                   err_r, err_nxt;
  logic [THREAD_BITS-1:0] woken_r, woken_nxt;

  logic in_acc;
  logic is_owner;
  logic mem_we;
  logic handoff_acc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign is_owner = held_r && (owner_r == in_thread_id);

  always_comb begin
    held_nxt     = held_r;
    owner_nxt    = owner_r;
    nest_nxt     = nest_r;
    head_ptr_nxt = head_ptr_r;
    tail_ptr_nxt = tail_ptr_r;
    fill_nxt     = fill_r;
    status_nxt   = ST_ERROR;
    err_nxt      = ERR_NONE;
    woken_nxt    = '0;
    mem_we       = 1'b0;
    if (in_acc) begin
      if (opcode_t'(in_opcode) == OP_LOCK) begin
        if (is_owner) begin
          if (nest_r == '1) begin
            err_nxt = ERR_OVERFLOW;
          end else begin
            nest_nxt   = nest_r + COUNT_BITS'(1);
            status_nxt = ST_NESTED;
          end
        end else if (!held_r) begin
          held_nxt   = 1'b1;
          owner_nxt  = in_thread_id;
          nest_nxt   = COUNT_BITS'(1);
          status_nxt = ST_GRANTED;
        end else if (fill_r == FILL_W'(QUEUE_DEPTH)) begin
          err_nxt = ERR_FULL;
        end else begin
          mem_we       = 1'b1;
          tail_ptr_nxt = (tail_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : tail_ptr_r + PTR_W'(1);
          fill_nxt     = fill_r + FILL_W'(1);
          status_nxt   = ST_QUEUED;
        end
      end else begin
        if (!is_owner) begin
          err_nxt = ERR_NOT_OWNER;
        end else if (nest_r != COUNT_BITS'(1)) begin
          nest_nxt   = nest_r - COUNT_BITS'(1);
          status_nxt = ST_STILL;
        end else if (fill_r != '0) begin
          owner_nxt    = head_data_r;
          head_ptr_nxt = (head_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : head_ptr_r + PTR_W'(1);
          fill_nxt     = fill_r - FILL_W'(1);
          nest_nxt     = COUNT_BITS'(1);
          woken_nxt    = head_data_r;
          status_nxt   = ST_HANDOFF;
        end else begin
          held_nxt   = 1'b0;
          owner_nxt  = '0;
          nest_nxt   = '0;
          status_nxt = ST_FREED;
        end
      end
    end
  end

  assign handoff_acc = in_acc && (status_nxt == ST_HANDOFF);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_ptr_r] <= in_thread_id;
    end
    if (mem_we && (tail_ptr_r == head_ptr_nxt)) begin
      head_data_r <= in_thread_id;
    end else begin
      head_data_r <= mem[head_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      owner_r     <= '0;
      nest_r      <= '0;
      head_ptr_r  <= '0;
      tail_ptr_r  <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_r     <= held_nxt;
      owner_r    <= owner_nxt;
      nest_r     <= nest_nxt;
      head_ptr_r <= head_ptr_nxt;
      tail_ptr_r <= tail_ptr_nxt;
      fill_r     <= fill_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      err_r    <= err_nxt;
      woken_r  <= woken_nxt;
    end
  end

  // The lock state registers hold the state after the last transaction while its result waits.
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_error_kind   = err_r;
  assign out_woken_thread = woken_r;
  assign out_owner_held   = held_r;
  assign out_owner_thread = owner_r;
  assign out_nest_depth   = nest_r;
  assign out_waiters      = fill_r;

  `RLFH_NEVER(a_free_has_no_waiters, clk, rst_n, !held_r && ((fill_r != '0) || (nest_r != '0)))
  `RLFH_NEVER(a_held_has_depth, clk, rst_n, held_r && (nest_r == '0))
  `RLFH_ASSERT(a_handoff_pops, clk, rst_n, handoff_acc |=> (fill_r == $past(fill_r) - FILL_W'(1)))
  `RLFH_ASSERT(a_result_follows, clk, rst_n, in_acc |=> out_valid_r)

endmodule
